// ===== hdl/lpfd_pkg.sv =====
package lpfd_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_EMPTY     = 2'd1,
		KIND_BAD_SYNC  = 2'd2,
		KIND_BAD_VER   = 2'd3
	} kind_t;

	// Configuration register indexes
	localparam int unsigned CfgIndexWidth = 8;
	typedef logic [CfgIndexWidth-1:0] cfg_index_t;

	localparam cfg_index_t REG_SYNC_FIRST  = cfg_index_t'(0);
	localparam cfg_index_t REG_SYNC_SECOND = cfg_index_t'(1);
	localparam cfg_index_t REG_EXP_VERSION = cfg_index_t'(2);
	localparam cfg_index_t REG_MAJOR_MASK  = cfg_index_t'(3);

	// Register reset values
	localparam logic [7:0] SyncFirstReset  = 8'h00;
	localparam logic [7:0] SyncSecondReset = 8'h00;
	localparam logic [7:0] ExpVersionReset = 8'h00;
	localparam logic [7:0] MajorMaskReset  = 8'hFF;

endpackage

// ===== hdl/length_prefixed_frame_deframer.sv =====
// Deframer for a sync/version/length-prefixed byte stream. Each accepted
// rx_byte advances a small header parser: two sync bytes, a version byte
// checked under major_mask, then a big-endian 16-bit length, after which that
// many bytes come out as kind 0 with last on the final one. A wrong sync or
// version byte comes out as an error kind carrying that byte and the parser
// resumes hunting; a zero length comes out as one empty-frame result. Header
// bytes that match give no result. The block takes one byte per clock: the
// parser state updates and the result loads into the output register in the
// same cycle, and in_ready is low only while that register holds a result
// that out_ready does not take. Write the configuration registers only while
// the stream is idle.
module length_prefixed_frame_deframer (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  lpfd_pkg::cfg_index_t     cfg_index,
	input  logic [7:0]               cfg_data,
	// input stream
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               rx_byte,
	// results
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               kind,
	output logic [7:0]               payload,
	output logic                     last
);
	import lpfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_VER   = 3'd2,
		PH_LENHI = 3'd3,
		PH_LENLO = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic [7:0]  exp_version_q;
	logic [7:0]  major_mask_q;

	phase_t      phase_q;
	phase_t      phase_d;
	logic [15:0] frame_len_q;
	logic [15:0] frame_len_d;
	logic [15:0] bytes_seen_q;
	logic [15:0] bytes_seen_d;

	logic        res_valid;
	kind_t       res_kind;
	logic [7:0]  res_payload;
	logic        res_last;
	logic [15:0] seen_inc;
	logic [15:0] len_full;

	logic        in_xfer;
	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  payload_q;
	logic        last_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign payload   = payload_q;
	assign last      = last_q;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SyncFirstReset;
			sync_second_q <= SyncSecondReset;
			exp_version_q <= ExpVersionReset;
			major_mask_q  <= MajorMaskReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				REG_EXP_VERSION: exp_version_q <= cfg_data;
				REG_MAJOR_MASK:  major_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign seen_inc = bytes_seen_q + 16'd1;
	assign len_full = {frame_len_q[15:8], rx_byte};

	// Parse one byte: next state and optional result
	always_comb begin
		phase_d      = phase_q;
		frame_len_d  = frame_len_q;
		bytes_seen_d = bytes_seen_q;
		res_valid    = 1'b0;
		res_kind     = KIND_PAYLOAD;
		res_payload  = rx_byte;
		res_last     = 1'b0;
		unique case (phase_q)
			PH_SYNC2: begin
				if (rx_byte == sync_second_q) begin
					phase_d = PH_VER;
				end else begin
					phase_d      = PH_HUNT;
					frame_len_d  = '0;
					bytes_seen_d = '0;
					res_valid    = 1'b1;
					res_kind     = KIND_BAD_SYNC;
				end
			end
			PH_VER: begin
				if ((rx_byte & major_mask_q) == (exp_version_q & major_mask_q)) begin
					phase_d = PH_LENHI;
				end else begin
					phase_d      = PH_HUNT;
					frame_len_d  = '0;
					bytes_seen_d = '0;
					res_valid    = 1'b1;
					res_kind     = KIND_BAD_VER;
				end
			end
			PH_LENHI: begin
				frame_len_d = {rx_byte, 8'h00};
				phase_d     = PH_LENLO;
			end
			PH_LENLO: begin
				bytes_seen_d = '0;
				if (len_full == 16'd0) begin
					phase_d     = PH_HUNT;
					frame_len_d = '0;
					res_valid   = 1'b1;
					res_kind    = KIND_EMPTY;
					res_payload = 8'h00;
				end else begin
					phase_d     = PH_DATA;
					frame_len_d = len_full;
				end
			end
			PH_DATA: begin
				res_valid    = 1'b1;
				res_kind     = KIND_PAYLOAD;
				bytes_seen_d = seen_inc;
				if (seen_inc >= frame_len_q) begin
					phase_d      = PH_HUNT;
					frame_len_d  = '0;
					bytes_seen_d = '0;
					res_last     = 1'b1;
				end
			end
			default: begin
				// hunting, including unused codes
				frame_len_d  = '0;
				bytes_seen_d = '0;
				if (rx_byte == sync_first_q) begin
					phase_d = PH_SYNC2;
				end else begin
					phase_d   = PH_HUNT;
					res_valid = 1'b1;
					res_kind  = KIND_BAD_SYNC;
				end
			end
		endcase
	end

	// Advance parser state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			frame_len_q  <= '0;
			bytes_seen_q <= '0;
		end else if (in_xfer) begin
			phase_q      <= phase_d;
			frame_len_q  <= frame_len_d;
			bytes_seen_q <= bytes_seen_d;
		end
	end

	// Output register: load on input transfer, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && res_valid) begin
			kind_q    <= res_kind;
			payload_q <= res_payload;
			last_q    <= res_last;
		end
	end

	// Checks
	a_last_only_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> kind_q == KIND_PAYLOAD)
		else $error("last set on a non-payload result");

	a_data_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> frame_len_q != 16'd0)
		else $error("payload phase with zero length");

	a_data_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> bytes_seen_q < frame_len_q)
		else $error("payload count reached frame length");

	a_last_returns_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && res_valid && res_last |=> phase_q == PH_HUNT && bytes_seen_q == 16'd0)
		else $error("parser not hunting after last payload byte");

endmodule
